// ===== sv/bfsk_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_pkg
// Shared constants, register codes, configuration and CORDIC stage types for
// the continuous-phase BFSK modulator.
// ---------------------------------------------------------------------------
package bfsk_pkg;

    // frame store depth default
    localparam int MAX_FRAME_BITS_DEF = 1024;

    // field widths
    localparam int INC_W       = 32;
    localparam int SPB_W       = 16;
    localparam int FB_W        = 11;
    localparam int BIT_INDEX_W = 10;
    localparam int PHASE_W     = 32;
    localparam int SAMPLE_W    = 16;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // apb widths
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // cordic datapath
    localparam int CORDIC_STEPS    = 24;
    localparam int STEPS_PER_STAGE = 4;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int CW              = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // register index codes
    typedef enum logic [1:0] {
        REG_PHASE_INC_MARK  = 2'd0,
        REG_PHASE_INC_SPACE = 2'd1,
        REG_SAMPLES_PER_BIT = 2'd2,
        REG_FRAME_BITS      = 2'd3
    } reg_idx_t;

    // input item kinds
    typedef enum logic {
        OP_WRITE_BIT = 1'b0,
        OP_SAMPLE    = 1'b1
    } op_t;

    // configuration register set
    typedef struct packed {
        logic [INC_W-1:0] phase_inc_mark;
        logic [INC_W-1:0] phase_inc_space;
        logic [SPB_W-1:0] samples_per_bit;
        logic [FB_W-1:0]  frame_bits;
    } cfg_t;

    // one sample in flight through the rotator
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
        logic                 done;
    } cordic_t;

    // arctangent of 2^-step, one turn = 2^32
    function automatic logic signed [CW-1:0] arc_angle(input logic [4:0] step);
        logic signed [CW-1:0] a;
        unique case (step)
            5'd0:    a = 34'sd536870912;
            5'd1:    a = 34'sd316933406;
            5'd2:    a = 34'sd167458907;
            5'd3:    a = 34'sd85004756;
            5'd4:    a = 34'sd42667331;
            5'd5:    a = 34'sd21354465;
            5'd6:    a = 34'sd10679838;
            5'd7:    a = 34'sd5340245;
            5'd8:    a = 34'sd2670163;
            5'd9:    a = 34'sd1335087;
            5'd10:   a = 34'sd667544;
            5'd11:   a = 34'sd333772;
            5'd12:   a = 34'sd166886;
            5'd13:   a = 34'sd83443;
            5'd14:   a = 34'sd41722;
            5'd15:   a = 34'sd20861;
            5'd16:   a = 34'sd10430;
            5'd17:   a = 34'sd5215;
            5'd18:   a = 34'sd2608;
            5'd19:   a = 34'sd1304;
            5'd20:   a = 34'sd652;
            5'd21:   a = 34'sd326;
            5'd22:   a = 34'sd163;
            5'd23:   a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/bfsk_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_regs
// APB register file holding the mark and space phase steps, the samples per
// bit and the frame length.
// ---------------------------------------------------------------------------
module bfsk_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfsk_pkg::APB_AW-1:0]  paddr,
    input  logic [bfsk_pkg::APB_DW-1:0]  pwdata,
    output logic [bfsk_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output bfsk_pkg::cfg_t               cfg
);
    import bfsk_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (sel)
                REG_PHASE_INC_MARK:  cfg_next.phase_inc_mark  = pwdata[INC_W-1:0];
                REG_PHASE_INC_SPACE: cfg_next.phase_inc_space = pwdata[INC_W-1:0];
                REG_SAMPLES_PER_BIT: cfg_next.samples_per_bit = pwdata[SPB_W-1:0];
                REG_FRAME_BITS:      cfg_next.frame_bits      = pwdata[FB_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_inc_mark  <= '0;
            cfg_reg.phase_inc_space <= '0;
            cfg_reg.samples_per_bit <= SPB_W'(1);
            cfg_reg.frame_bits      <= FB_W'(1024);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb begin
        unique case (sel)
            REG_PHASE_INC_MARK:  prdata = APB_DW'(cfg_reg.phase_inc_mark);
            REG_PHASE_INC_SPACE: prdata = APB_DW'(cfg_reg.phase_inc_space);
            REG_SAMPLES_PER_BIT: prdata = APB_DW'(cfg_reg.samples_per_bit);
            REG_FRAME_BITS:      prdata = APB_DW'(cfg_reg.frame_bits);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/bfsk_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_ctrl
// Frame bit store, bit and sample counters, and the phase accumulator. Emits
// the rotator start values for each sample in order.
// ---------------------------------------------------------------------------
module bfsk_ctrl #(
    parameter int MAX_FRAME_BITS = bfsk_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bfsk_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfsk_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bfsk_pkg::cordic_t              out_data
);
    import bfsk_pkg::*;

    localparam int IDX_W = $clog2(MAX_FRAME_BITS);
    localparam int CNT_W = $clog2(MAX_FRAME_BITS + 1);
    localparam int LIM_W = (CNT_W > FB_W) ? CNT_W : FB_W;
    localparam int WA_W  = (CNT_W > BIT_INDEX_W) ? CNT_W : BIT_INDEX_W;

    // frame bit store
    logic mem [MAX_FRAME_BITS];

    // control state
    logic [SPB_W-1:0]   sib_reg, sib_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PHASE_W-1:0] phase_reg;
    logic               s1_valid_reg, s2_valid_reg;

    // payload
    logic    s1_bit_reg, s1_done_reg;
    cordic_t s2_data_reg;

    logic                   accept, wr_en, rd_en, s1_ready, s2_ready, s1_move;
    op_t                    op;
    logic [WA_W-1:0]        wa_ext;
    logic [SPB_W-1:0]       spb_eff;
    logic [LIM_W-1:0]       fb_ext, fb_lim, idx_inc;
    logic [SPB_W:0]         sib_inc;
    logic                   wrap_bit, wrap_frame;
    logic [PHASE_W-1:0]     p_round, d_val, inc_sel;
    logic [1:0]             quad;

    // input transaction decode
    assign op      = op_t'(s_tuser);
    assign accept  = s_tvalid & s_tready;
    assign wa_ext  = WA_W'(s_tdata[BIT_INDEX_W-1:0]);
    assign wr_en   = accept && (op == OP_WRITE_BIT) && (wa_ext < WA_W'(MAX_FRAME_BITS));
    assign rd_en   = accept && (op == OP_SAMPLE);

    // effective limits
    assign spb_eff = (cfg.samples_per_bit == '0) ? SPB_W'(1) : cfg.samples_per_bit;
    assign fb_ext  = LIM_W'(cfg.frame_bits);

    always_comb begin
        if (fb_ext == '0) begin
            fb_lim = LIM_W'(1);
        end else if (fb_ext > LIM_W'(MAX_FRAME_BITS)) begin
            fb_lim = LIM_W'(MAX_FRAME_BITS);
        end else begin
            fb_lim = fb_ext;
        end
    end

    // sample and bit counters
    assign sib_inc    = {1'b0, sib_reg} + 1'b1;
    assign wrap_bit   = sib_inc >= {1'b0, spb_eff};
    assign idx_inc    = LIM_W'(idx_reg) + 1'b1;
    assign wrap_frame = wrap_bit && (idx_inc >= fb_lim);

    always_comb begin
        sib_next = sib_reg;
        idx_next = idx_reg;
        if (rd_en) begin
            if (wrap_bit) begin
                sib_next = '0;
                idx_next = wrap_frame ? '0 : idx_inc[IDX_W-1:0];
            end else begin
                sib_next = sib_inc[SPB_W-1:0];
            end
        end else if (accept && s_tlast) begin
            sib_next = '0;
            idx_next = '0;
        end
    end

    // stage handshake
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s1_move  = s1_valid_reg && s2_ready;
    assign s_tready = s1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sib_reg      <= '0;
            idx_reg      <= '0;
            phase_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            sib_reg <= sib_next;
            idx_reg <= idx_next;
            if (s1_ready) begin
                s1_valid_reg <= rd_en;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move) begin
                phase_reg <= phase_reg + inc_sel;
            end
        end
    end

    // store write and registered read of the current bit
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wa_ext[IDX_W-1:0]] <= s_tdata[BIT_INDEX_W];
        end
        if (rd_en) begin
            s1_bit_reg  <= mem[idx_reg];
            s1_done_reg <= wrap_frame;
        end
    end

    // quarter-turn reduction of the phase
    assign inc_sel = s1_bit_reg ? cfg.phase_inc_mark : cfg.phase_inc_space;
    assign p_round = phase_reg + 32'h2000_0000;
    assign quad    = p_round[PHASE_W-1:PHASE_W-2];
    assign d_val   = phase_reg - {quad, 30'd0};

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_data_reg.x    <= CORDIC_GAIN;
            s2_data_reg.y    <= '0;
            s2_data_reg.z    <= {{(CW-PHASE_W){d_val[PHASE_W-1]}}, d_val};
            s2_data_reg.quad <= quad;
            s2_data_reg.done <= s1_done_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = s2_data_reg;

    // a stalled sample keeps its bit
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_bit_reg)))
        else $error("stalled sample lost its frame bit");

    // a frame-last write restarts the position
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (op == OP_WRITE_BIT) && s_tlast) |=> (sib_reg == '0 && idx_reg == '0))
        else $error("frame-last write did not restart the sample position");

    // phase only moves with a sample
    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_move |=> $stable(phase_reg))
        else $error("phase accumulator changed without a sample");

    // reset empties the front stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!s1_valid_reg && !s2_valid_reg))
        else $error("front stages not empty after reset");

endmodule

// ===== sv/bfsk_cordic_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_cordic_stage
// One registered stage of the rotation-mode CORDIC, STEPS_PER_STAGE micro-rotations
// per stage, with its own valid and ready.
// ---------------------------------------------------------------------------
module bfsk_cordic_stage #(
    parameter int FIRST_STEP = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bfsk_pkg::cordic_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bfsk_pkg::cordic_t out_data
);
    import bfsk_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // micro-rotations toward zero residual angle
    always_comb begin
        logic signed [CW-1:0] x, y, z, nx, ny;
        x = in_data.x;
        y = in_data.y;
        z = in_data.z;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> (FIRST_STEP + i));
                ny = y + (x >>> (FIRST_STEP + i));
                z  = z - arc_angle(5'(FIRST_STEP + i));
            end else begin
                nx = x + (y >>> (FIRST_STEP + i));
                ny = y - (x >>> (FIRST_STEP + i));
                z  = z + arc_angle(5'(FIRST_STEP + i));
            end
            x = nx;
            y = ny;
        end
        data_next      = in_data;
        data_next.x    = x;
        data_next.y    = y;
        data_next.z    = z;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/bfsk_out.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_out
// Quarter-turn mapping, Q30 to sample scaling with saturation, and the
// output register on the master stream.
// ---------------------------------------------------------------------------
module bfsk_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bfsk_pkg::cordic_t              in_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bfsk_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import bfsk_pkg::*;

    localparam int PW = CW + SAMPLE_W + 1;
    localparam logic signed [PW-1:0] AMP     = PW'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] AMP_MIN = -AMP - PW'(1);
    localparam logic signed [PW-1:0] ROUND   = PW'(64'sd1 <<< 29);

    logic                      m_valid_reg;
    logic [SAMPLE_W-1:0]       cos_reg, sin_reg;
    logic                      done_reg;
    logic signed [CW-1:0]      c_val, s_val;
    logic [SAMPLE_W-1:0]       cos_next, sin_next;

    // scale to sample amplitude, round by floor with half offset, saturate
    function automatic logic [SAMPLE_W-1:0] scale_out(input logic signed [CW-1:0] v);
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] r;
        prod = PW'(v) * AMP + ROUND;
        r    = prod >>> 30;
        if (r > AMP) begin
            r = AMP;
        end else if (r < AMP_MIN) begin
            r = AMP_MIN;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    // quarter-turn swap and negate
    always_comb begin
        unique case (in_data.quad)
            2'd0: begin c_val = in_data.x;  s_val = in_data.y;  end
            2'd1: begin c_val = -in_data.y; s_val = in_data.x;  end
            2'd2: begin c_val = -in_data.x; s_val = -in_data.y; end
            2'd3: begin c_val = in_data.y;  s_val = -in_data.x; end
        endcase
    end

    assign cos_next = scale_out(c_val);
    assign sin_next = scale_out(s_val);

    // output register
    assign in_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            done_reg <= in_data.done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {sin_reg, cos_reg};
    assign m_tlast  = done_reg;

endmodule

// ===== sv/bfsk_frame_modulator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_frame_modulator
// Continuous-phase binary FSK modulator over a stored frame: a frame bit
// store, phase accumulator and pipelined CORDIC giving cosine and sine.
//
//   channel  dir  carries
//   s_       in   frame bit writes and sample requests (tuser = kind)
//   m_       out  cos/sin sample pairs, tlast marks the frame wrap
//   apb      in   mark/space phase steps, samples per bit, frame length
//
// One item per clock while m_tready does not hold the pipeline back; a sample passes
// through the front stage (bit read, loaded at the accepting edge), the phase
// stage, six CORDIC stages and the output register.
// Bit writes are stored and give no result.
// Reset is synchronous and empties the pipeline; the frame store is not
// cleared, so bits must be written before they are played.
// Each stage holds while the next is full, so bubbles still let items in
// while a result waits on m_tready.
// ---------------------------------------------------------------------------
module bfsk_frame_modulator #(
    parameter int MAX_FRAME_BITS = bfsk_pkg::MAX_FRAME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bfsk_pkg::S_TDATA_W-1:0] s_tdata,  // bit_index[9:0], bit_value[10], zero pad
    input  logic                           s_tuser,  // operation
    input  logic                           s_tlast,  // frame_last
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bfsk_pkg::M_TDATA_W-1:0] m_tdata,  // out_cos[15:0], out_sin[31:16]
    output logic                           m_tlast,  // frame_done
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfsk_pkg::APB_AW-1:0]    paddr,
    input  logic [bfsk_pkg::APB_DW-1:0]    pwdata,
    output logic [bfsk_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import bfsk_pkg::*;

    cfg_t    cfg;
    logic    cv [CORDIC_STAGES+1];
    logic    cr [CORDIC_STAGES+1];
    cordic_t cd [CORDIC_STAGES+1];

    // configuration registers
    bfsk_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame store, counters and phase
    bfsk_ctrl #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    // cordic pipeline
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        bfsk_cordic_stage #(
            .FIRST_STEP (g * STEPS_PER_STAGE)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[g]),
            .in_ready  (cr[g]),
            .in_data   (cd[g]),
            .out_valid (cv[g+1]),
            .out_ready (cr[g+1]),
            .out_data  (cd[g+1])
        );
    end

    // scaling and output register
    bfsk_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cv[CORDIC_STAGES]),
        .in_ready (cr[CORDIC_STAGES]),
        .in_data  (cd[CORDIC_STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== bench/bfsk_frame_modulator_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bfsk_frame_modulator_test
// Self-checking bench for the BFSK frame modulator. Frame bits and sample
// requests go in on the input stream, phase steps and frame geometry are
// programmed over APB, and every output sample is compared against a
// bit-exact predictor of the phase accumulator, bit sequencer and CORDIC.
// ---------------------------------------------------------------------------
module bfsk_frame_modulator_test;
    import bfsk_pkg::*;

    localparam int     STORE_DEPTH     = 1024;
    localparam int     LONG_FRAME_BITS = 128;
    localparam int     DRAIN_CYCLES    = 16;
    localparam longint Q15_MAX         = 32767;

    // one predicted output sample
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] i_val;
        logic signed [SAMPLE_W-1:0] q_val;
        logic                       wrap;
    } tone_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // bit_index[9:0], bit_value[10], zero pad
    logic                 s_tuser  = 1'b0; // operation
    logic                 s_tlast  = 1'b0; // frame_last
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // out_cos[15:0], out_sin[31:16]
    logic                 m_tlast;         // frame_done
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor copy of the registers
    logic [INC_W-1:0] cfg_mark  = '0;
    logic [INC_W-1:0] cfg_space = '0;
    logic [SPB_W-1:0] cfg_spb   = SPB_W'(1);
    logic [FB_W-1:0]  cfg_fb    = FB_W'(1024);

    // predictor copy of the datapath state
    logic             frame_store [STORE_DEPTH];
    bit               bit_loaded  [STORE_DEPTH];
    logic [PHASE_W-1:0] acc_phase = '0;
    int unsigned      spb_count   = 0;
    int unsigned      bit_pos     = 0;

    tone_t            tones_due [$];

    int unsigned fail_count    = 0;
    int unsigned tones_checked = 0;
    int unsigned bits_written  = 0;
    int unsigned wraps_seen    = 0;
    int unsigned send_idle_pct = 24;
    int unsigned recv_idle_pct = 50;

    bfsk_frame_modulator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // arctangent of 2^-n, one turn = 2^32
    function automatic longint atan_step(input int n);
        case (n)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            default: return 0;
        endcase
    endfunction

    // q30 to q1.15 with round half up and saturation
    function automatic logic signed [SAMPLE_W-1:0] to_q15(input longint v);
        longint r;
        r = (v * Q15_MAX + 64'sd536870912) >>> 30;
        if (r > Q15_MAX)
            r = Q15_MAX;
        if (r < -Q15_MAX - 1)
            r = -Q15_MAX - 1;
        return r[SAMPLE_W-1:0];
    endfunction

    // cosine and sine of the phase: quarter-turn fold, then 24-step rotation
    function automatic tone_t rotate_carrier(input logic [PHASE_W-1:0] ph);
        logic [31:0] rounded;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, nx, ny, c, s;
        int          n;
        tone_t       t;
        rounded = ph + 32'h2000_0000;
        quad    = rounded[31:30];
        resid   = ph - {quad, 30'd0};
        x       = 652032874;
        y       = 0;
        z       = longint'($signed(resid));
        for (n = 0; n < 24; n++) begin
            if (z >= 0) begin
                nx = x - (y >>> n);
                ny = y + (x >>> n);
                z  = z - atan_step(n);
            end else begin
                nx = x + (y >>> n);
                ny = y - (x >>> n);
                z  = z + atan_step(n);
            end
            x = nx;
            y = ny;
        end
        case (quad)
            2'd0: begin
                c = x;
                s = y;
            end
            2'd1: begin
                c = -y;
                s = x;
            end
            2'd2: begin
                c = -x;
                s = -y;
            end
            default: begin
                c = y;
                s = -x;
            end
        endcase
        t.i_val = to_q15(c);
        t.q_val = to_q15(s);
        t.wrap  = 1'b0;
        return t;
    endfunction

    // one sample request: emit, step the phase, advance the bit sequencer
    function automatic tone_t model_tone();
        int unsigned spb, fb;
        tone_t       t;
        spb = (cfg_spb == 0) ? 1 : cfg_spb;
        fb  = (cfg_fb == 0) ? 1 : ((cfg_fb > STORE_DEPTH) ? STORE_DEPTH : cfg_fb);
        t = rotate_carrier(acc_phase);
        acc_phase = acc_phase + (frame_store[bit_pos] ? cfg_mark : cfg_space);
        spb_count++;
        if (spb_count >= spb) begin
            spb_count = 0;
            bit_pos++;
            if (bit_pos >= fb) begin
                bit_pos = 0;
                t.wrap  = 1'b1;
            end
        end
        return t;
    endfunction

    // drive one input transaction and update the predictor when it is taken
    task automatic put_item(input op_t op, input logic [BIT_INDEX_W-1:0] idx,
                            input logic val, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {{(S_TDATA_W - BIT_INDEX_W - 1){1'b0}}, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (op == OP_WRITE_BIT) begin
            frame_store[idx] = val;
            bit_loaded[idx]  = 1'b1;
            bits_written++;
            if (last) begin
                spb_count = 0;
                bit_pos   = 0;
            end
        end else begin
            tones_due.push_back(model_tone());
        end
    endtask

    // sample request, loading the bit it will play first if still unknown
    task automatic play_tone();
        if (!bit_loaded[bit_pos])
            put_item(OP_WRITE_BIT, BIT_INDEX_W'(bit_pos), 1'($urandom), 1'b0);
        put_item(OP_SAMPLE, BIT_INDEX_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // stop sending and let the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tones_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // apb write, setup then access
    task automatic cfg_write(input reg_idx_t r, input logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({r, 2'b00});
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_PHASE_INC_MARK:  cfg_mark  = v[INC_W-1:0];
            REG_PHASE_INC_SPACE: cfg_space = v[INC_W-1:0];
            REG_SAMPLES_PER_BIT: cfg_spb   = v[SPB_W-1:0];
            default:             cfg_fb    = v[FB_W-1:0];
        endcase
    endtask

    // apb read compared with the predictor's register copy
    task automatic cfg_check(input reg_idx_t r);
        logic [APB_DW-1:0] want;
        case (r)
            REG_PHASE_INC_MARK:  want = APB_DW'(cfg_mark);
            REG_PHASE_INC_SPACE: want = APB_DW'(cfg_space);
            REG_SAMPLES_PER_BIT: want = APB_DW'(cfg_spb);
            default:             want = APB_DW'(cfg_fb);
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({r, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: register %s expected %h actual %h", $time, r.name(), want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // reset values, then write and read back every register
    task automatic test_registers();
        cfg_check(REG_PHASE_INC_MARK);
        cfg_check(REG_PHASE_INC_SPACE);
        cfg_check(REG_SAMPLES_PER_BIT);
        cfg_check(REG_FRAME_BITS);
        cfg_write(REG_PHASE_INC_MARK, 32'hA5A5_5A5A);
        cfg_write(REG_PHASE_INC_SPACE, 32'h5A5A_A5A5);
        cfg_write(REG_SAMPLES_PER_BIT, 32'h0000_FFFF);
        cfg_write(REG_FRAME_BITS, 32'd1024);
        cfg_check(REG_PHASE_INC_MARK);
        cfg_check(REG_PHASE_INC_SPACE);
        cfg_check(REG_SAMPLES_PER_BIT);
        cfg_check(REG_FRAME_BITS);
    endtask

    // short frame in eighth-turn steps, top store index, restart mid-frame
    task automatic test_directed();
        cfg_write(REG_PHASE_INC_MARK, 32'h2000_0000);
        cfg_write(REG_PHASE_INC_SPACE, 32'hE000_0000);
        cfg_write(REG_SAMPLES_PER_BIT, 32'd1);
        cfg_write(REG_FRAME_BITS, 32'd4);
        put_item(OP_WRITE_BIT, 10'd0, 1'b1, 1'b0);
        put_item(OP_WRITE_BIT, 10'd1, 1'b1, 1'b0);
        put_item(OP_WRITE_BIT, 10'd2, 1'b0, 1'b0);
        put_item(OP_WRITE_BIT, 10'd3, 1'b1, 1'b1);
        put_item(OP_WRITE_BIT, 10'h3FF, 1'b1, 1'b0);
        repeat (8) play_tone();
        repeat (2) play_tone();
        put_item(OP_WRITE_BIT, 10'd2, 1'b0, 1'b1);
        repeat (3) play_tone();
        wait_idle();
    endtask

    // counters left beyond a newly reduced limit wrap on the next sample,
    // zero limits act as one
    task automatic test_shrunk_limits();
        cfg_write(REG_PHASE_INC_MARK, 32'h0123_4567);
        cfg_write(REG_PHASE_INC_SPACE, 32'h89AB_CDEF);
        cfg_write(REG_SAMPLES_PER_BIT, 32'd4);
        cfg_write(REG_FRAME_BITS, 32'd16);
        repeat (14) play_tone();
        wait_idle();
        cfg_write(REG_SAMPLES_PER_BIT, 32'd1);
        cfg_write(REG_FRAME_BITS, 32'd2);
        repeat (4) play_tone();
        wait_idle();
        cfg_write(REG_SAMPLES_PER_BIT, 32'd0);
        cfg_write(REG_FRAME_BITS, 32'd0);
        repeat (3) play_tone();
        wait_idle();
    endtask

    // largest and smallest phase steps, longest bit, frame length above the store
    task automatic test_phase_extremes();
        cfg_write(REG_PHASE_INC_MARK, 32'hFFFF_FFFF);
        cfg_write(REG_PHASE_INC_SPACE, 32'h8000_0000);
        cfg_write(REG_SAMPLES_PER_BIT, 32'd65535);
        cfg_write(REG_FRAME_BITS, 32'd2047);
        put_item(OP_WRITE_BIT, 10'd0, 1'b1, 1'b1);
        repeat (6) play_tone();
        put_item(OP_WRITE_BIT, 10'd0, 1'b0, 1'b1);
        repeat (4) play_tone();
        wait_idle();
        cfg_write(REG_PHASE_INC_MARK, 32'h0000_0000);
        cfg_write(REG_PHASE_INC_SPACE, 32'h0000_0000);
        repeat (3) play_tone();
        wait_idle();
    endtask

    // random settings, mostly sample requests with bit loads and restarts
    task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct);
        int unsigned pick, fb, lim;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (2) begin
            cfg_write(REG_PHASE_INC_MARK, $urandom);
            cfg_write(REG_PHASE_INC_SPACE, $urandom);
            pick = $urandom_range(9);
            cfg_write(REG_SAMPLES_PER_BIT, (pick < 6) ? $urandom_range(4, 1) :
                      (pick < 9) ? $urandom_range(40, 5) : $urandom_range(65535, 1));
            pick = $urandom_range(9);
            fb = (pick < 6) ? $urandom_range(12, 1) :
                 (pick < 8) ? $urandom_range(1023, 13) : 1024;
            cfg_write(REG_FRAME_BITS, fb);
            repeat (65) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    play_tone();
                end else begin
                    lim = (pick < 88) ? fb - 1 : STORE_DEPTH - 1;
                    put_item(OP_WRITE_BIT, BIT_INDEX_W'($urandom_range(lim)), 1'($urandom),
                             1'($urandom_range(99) < 15));
                end
            end
            wait_idle();
        end
    endtask

    // long frame at one sample per bit, through its wrap
    task automatic test_full_frame();
        int i;
        cfg_write(REG_PHASE_INC_MARK, $urandom);
        cfg_write(REG_PHASE_INC_SPACE, $urandom);
        cfg_write(REG_SAMPLES_PER_BIT, 32'd1);
        cfg_write(REG_FRAME_BITS, APB_DW'(LONG_FRAME_BITS));
        for (i = 0; i < LONG_FRAME_BITS; i++)
            put_item(OP_WRITE_BIT, BIT_INDEX_W'(i), 1'($urandom), i == LONG_FRAME_BITS - 1);
        repeat (LONG_FRAME_BITS + 6) play_tone();
        wait_idle();
    endtask

    // result side: random stalls and comparison with the oldest prediction
    always @(posedge aclk) begin : tone_checker
        tone_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tones_due.size() == 0) begin
                $display("%0t: unexpected output transaction, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = tones_due.pop_front();
                tones_checked++;
                if (m_tlast === 1'b1)
                    wraps_seen++;
                if (m_tdata[15:0] !== want.i_val) begin
                    $display("%0t: out_cos expected %0d actual %0d", $time, want.i_val,
                             $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tdata[31:16] !== want.q_val) begin
                    $display("%0t: out_sin expected %0d actual %0d", $time, want.q_val,
                             $signed(m_tdata[31:16]));
                    fail_count++;
                end
                if (m_tlast !== want.wrap) begin
                    $display("%0t: frame_done expected %b actual %b", $time, want.wrap, m_tlast);
                    fail_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // test sequence
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_registers();
        test_directed();
        test_shrunk_limits();
        test_phase_extremes();
        test_random(24, 50);
        test_random(50, 24);
        test_random(0, 0);
        test_full_frame();
        $display("covered %0d bit loads, %0d checked samples, %0d frame wraps", bits_written,
                 tones_checked, wraps_seen);
        $display("register access, restarts, shrunk and zero limits, phase extremes, long frame");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end

endmodule
